>>> rtl/trz_pkg.sv
// Shared types, constants and arithmetic helpers of the triangle rasterizer.
package trz_pkg;

	localparam int SCREEN_WIDTH  = 256;
	localparam int SCREEN_HEIGHT = 256;
	localparam int DEPTH_BITS    = 24;

	localparam int PIX_TOTAL = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int ADDR_W    = $clog2(PIX_TOTAL);
	localparam int XW        = $clog2(SCREEN_WIDTH);
	localparam int YW        = $clog2(SCREEN_HEIGHT);

	localparam int CRW  = 16;
	localparam int DIFW = CRW + 1;
	localparam int PDW  = 2 * DIFW;
	localparam int EW   = PDW + 1;
	localparam int ZW   = 24;
	localparam int PZW  = DIFW + ZW + 1;
	localparam int SPLIT = 18;
	localparam int PHW  = (EW - SPLIT) + ZW + 1;
	localparam int PLW  = SPLIT + 1 + ZW + 1;
	localparam int NW   = 64;
	localparam int CNTW = 17;
	localparam int CMPW = (DEPTH_BITS > ZW) ? DEPTH_BITS : ZW;

	localparam logic [CNTW-1:0]       COUNT_MAX  = '1;
	localparam logic [DEPTH_BITS-1:0] DEPTH_FAR  = '1;
	localparam logic signed [CRW-1:0] X_LAST     = CRW'(SCREEN_WIDTH - 1);
	localparam logic signed [CRW-1:0] Y_LAST     = CRW'(SCREEN_HEIGHT - 1);

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_DRAW  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [XW-1:0]     xpos_t;
	typedef logic [YW-1:0]     ypos_t;

	typedef struct packed {
		logic [1:0]            operation;
		logic signed [CRW-1:0] ax;
		logic signed [CRW-1:0] ay;
		logic [ZW-1:0]         az;
		logic signed [CRW-1:0] bx;
		logic signed [CRW-1:0] by_row;
		logic [ZW-1:0]         bz;
		logic signed [CRW-1:0] cx;
		logic signed [CRW-1:0] cy;
		logic [ZW-1:0]         cz;
		logic [23:0]           fill_rgb;
	} trz_cmd_t;

	typedef struct packed {
		logic [31:0]     pixel_colour;
		logic [23:0]     pixel_depth;
		logic [CNTW-1:0] pixels_written;
		logic            degenerate;
	} trz_rsp_t;

	function automatic logic signed [DIFW-1:0] diff(input logic signed [CRW-1:0] a,
		input logic signed [CRW-1:0] b);
		return DIFW'(a) - DIFW'(b);
	endfunction

	function automatic logic signed [CRW-1:0] min3(input logic signed [CRW-1:0] a,
		input logic signed [CRW-1:0] b, input logic signed [CRW-1:0] c);
		logic signed [CRW-1:0] m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	function automatic logic signed [CRW-1:0] max3(input logic signed [CRW-1:0] a,
		input logic signed [CRW-1:0] b, input logic signed [CRW-1:0] c);
		logic signed [CRW-1:0] m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	function automatic logic signed [PDW-1:0] mul_dd(input logic signed [DIFW-1:0] a,
		input logic signed [DIFW-1:0] b);
		return PDW'(a) * PDW'(b);
	endfunction

	function automatic logic signed [PZW-1:0] mul_dz(input logic signed [DIFW-1:0] a,
		input logic [ZW-1:0] z);
		logic signed [PZW-1:0] zs;
		zs = $signed(PZW'(z));
		return PZW'(a) * zs;
	endfunction

endpackage

>>> rtl/trz_cmd_if.sv
// Command channel carrying one operation beat into the rasterizer.
interface trz_cmd_if import trz_pkg::*; ();
	logic     valid;
	logic     ready;
	trz_cmd_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> rtl/trz_rsp_if.sv
// Response channel carrying one result beat out of the rasterizer.
interface trz_rsp_if import trz_pkg::*; ();
	logic     valid;
	logic     ready;
	trz_rsp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> rtl/trz_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module trz_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

>>> rtl/trz_div.sv
// Restoring divider that produces one quotient bit of the pixel depth per cycle.
module trz_div import trz_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [NW-2:0]   num,
	input  logic [EW-1:0]   den,
	output logic            done,
	output logic [ZW-1:0]   quot
);
	localparam int SW = $clog2(ZW);

	logic [NW-2:0] rem_q;
	logic [NW-2:0] dsh_q;
	logic [ZW-1:0] quot_q;
	logic [SW-1:0] step_q;
	logic          busy_q;
	logic          done_q;
	logic          ge;

	assign ge   = rem_q >= dsh_q;
	assign done = done_q;
	assign quot = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == SW'(ZW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			dsh_q  <= (NW - 1)'(den) << (ZW - 1);
			quot_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quot_q <= {quot_q[ZW-2:0], ge};
			dsh_q  <= dsh_q >> 1;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q)
		else $error("divider reports done while still busy");
endmodule

>>> rtl/triangle_raster_zbuffer_unit.sv
// Top level of the edge-function triangle rasterizer with colour and depth stores.
// Commands arrive as beats on cmd; every command gives exactly one beat on rsp.
// Clear sweeps both stores, one pixel per cycle, over all PIX_TOTAL pixels
// (65536 at 256 x 256), and then gives its response.
// Read returns the stored colour word and depth.
// Draw runs the setup states ST_SET1 to ST_SET5, computing the edge functions,
// the depth plane and the clipped bounding box, then walks the box one pixel at a time.
// A pixel outside the triangle is passed in ST_PIX alone; a covered pixel also
// waits in ST_DIVW for the bit-serial depth divider, followed by the depth test
// and the write-back into the two single-port-write memories.
// A degenerate or fully clipped triangle responds right after setup.
// After reset the block runs the same clearing pass and accepts no command until
// it ends; it sends no response for it.
// One command is processed at a time. A finished response waits in an output
// register, so while the receiver stalls the block still takes the next
// command and works on it; it holds only when a second response is ready.
module triangle_raster_zbuffer_unit import trz_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	trz_cmd_if.sink    cmd,
	trz_rsp_if.source  rsp
);
	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_SET1 = 11'b000_0000_0010,
		ST_SET2 = 11'b000_0000_0100,
		ST_SET3 = 11'b000_0000_1000,
		ST_SET4 = 11'b000_0001_0000,
		ST_SET5 = 11'b000_0010_0000,
		ST_PIX  = 11'b000_0100_0000,
		ST_DIVW = 11'b000_1000_0000,
		ST_RDW  = 11'b001_0000_0000,
		ST_CLR  = 11'b010_0000_0000,
		ST_FIN  = 11'b100_0000_0000
	} state_t;

	state_t   state_q;
	trz_cmd_t cmd_q;
	trz_rsp_t res_q;
	trz_rsp_t rsp_q;
	logic     rsp_valid_q;
	logic     pend_q;
	addr_t    clr_addr_q;

	logic signed [DIFW-1:0] dx_q [3];
	logic signed [DIFW-1:0] dy_q [3];
	logic signed [DIFW-1:0] ox_q [3];
	logic signed [DIFW-1:0] oy_q [3];
	logic signed [DIFW-1:0] acx_q, acy_q;
	xpos_t                  xlo_q, xhi_q, x_q;
	ypos_t                  ylo_q, yhi_q, y_q;
	logic                   empty_q;

	logic signed [PDW-1:0] pex_q [3];
	logic signed [PDW-1:0] pey_q [3];
	logic signed [PDW-1:0] parx_q, pary_q;
	logic signed [PZW-1:0] pnx_q [3];
	logic signed [PZW-1:0] pny_q [3];

	logic signed [EW-1:0] area_q;
	logic signed [EW-1:0] e_q  [3];
	logic signed [EW-1:0] er_q [3];
	logic signed [NW-1:0] nx_q, ny_q;
	logic signed [PHW-1:0] ph_q [3];
	logic signed [PLW-1:0] pl_q [3];
	logic signed [NW-1:0] num_q, numrow_q;
	addr_t                idx_q, rowidx_q;
	logic [CNTW-1:0]      cnt_q;

	logic [ZW-1:0]          zv [3];
	logic signed [CRW-1:0]  xlo16, xhi16, ylo16, yhi16;
	logic                   accept;
	logic                   rd_onscreen;
	addr_t                  rd_idx;
	logic                   area_pos;
	logic                   covered;
	logic signed [NW-1:0]   num_adj;
	logic [NW-2:0]          div_num;
	logic [EW-1:0]          div_den;
	logic                   div_start;
	logic                   div_done;
	logic [ZW-1:0]          div_quot;
	logic [DEPTH_BITS-1:0]  zsat;
	logic                   wr_pix;
	logic                   adv;
	logic [CNTW-1:0]        cnt_nxt;
	logic signed [NW-1:0]   n0;
	logic                   out_free;

	logic                  dep_we, ram_re;
	addr_t                 ram_waddr, ram_raddr;
	logic [DEPTH_BITS-1:0] dep_wdata, dep_rdata;
	logic [31:0]           col_wdata, col_rdata;

	assign zv[0] = cmd_q.az;
	assign zv[1] = cmd_q.bz;
	assign zv[2] = cmd_q.cz;

	assign xlo16 = (min3(cmd_q.ax, cmd_q.bx, cmd_q.cx) < 0) ? '0 :
		min3(cmd_q.ax, cmd_q.bx, cmd_q.cx);
	assign xhi16 = (max3(cmd_q.ax, cmd_q.bx, cmd_q.cx) > X_LAST) ? X_LAST :
		max3(cmd_q.ax, cmd_q.bx, cmd_q.cx);
	assign ylo16 = (min3(cmd_q.ay, cmd_q.by_row, cmd_q.cy) < 0) ? '0 :
		min3(cmd_q.ay, cmd_q.by_row, cmd_q.cy);
	assign yhi16 = (max3(cmd_q.ay, cmd_q.by_row, cmd_q.cy) > Y_LAST) ? Y_LAST :
		max3(cmd_q.ay, cmd_q.by_row, cmd_q.cy);

	assign accept      = cmd.valid && cmd.ready;
	assign cmd.ready   = (state_q == ST_IDLE);
	assign rd_onscreen = (cmd.data.ax >= 0) && (cmd.data.ax <= X_LAST) &&
		(cmd.data.ay >= 0) && (cmd.data.ay <= Y_LAST);
	assign rd_idx = ADDR_W'(cmd.data.ay[YW-1:0]) * ADDR_W'(SCREEN_WIDTH) +
		ADDR_W'(cmd.data.ax[XW-1:0]);

	assign area_pos = !area_q[EW-1];
	assign covered = area_pos ?
		(!e_q[0][EW-1] && !e_q[1][EW-1] && !e_q[2][EW-1]) :
		((e_q[0][EW-1] || e_q[0] == '0) && (e_q[1][EW-1] || e_q[1] == '0) &&
		 (e_q[2][EW-1] || e_q[2] == '0));

	assign num_adj   = area_pos ? num_q : -num_q;
	assign div_num   = (num_adj > 0) ? num_adj[NW-2:0] : '0;
	assign div_den   = area_pos ? area_q : -area_q;
	assign div_start = (state_q == ST_PIX) && covered;

	assign zsat = (CMPW'(div_quot) > CMPW'(DEPTH_FAR)) ? DEPTH_FAR : DEPTH_BITS'(div_quot);
	assign wr_pix = (state_q == ST_DIVW) && div_done && (zsat < dep_rdata);
	assign adv = ((state_q == ST_PIX) && !covered) || ((state_q == ST_DIVW) && div_done);
	assign cnt_nxt = (wr_pix && cnt_q != COUNT_MAX) ? cnt_q + 1'b1 : cnt_q;

	assign n0 = (NW'(ph_q[0]) <<< SPLIT) + NW'(pl_q[0]) +
		(NW'(ph_q[1]) <<< SPLIT) + NW'(pl_q[1]) +
		(NW'(ph_q[2]) <<< SPLIT) + NW'(pl_q[2]);

	assign out_free = !rsp_valid_q || rsp.ready;

	assign dep_we    = (state_q == ST_CLR) || wr_pix;
	assign ram_waddr = (state_q == ST_CLR) ? clr_addr_q : idx_q;
	assign dep_wdata = (state_q == ST_CLR) ? DEPTH_FAR : zsat;
	assign col_wdata = (state_q == ST_CLR) ? 32'h0 : {cmd_q.fill_rgb, 8'hFF};
	assign ram_re    = (accept && cmd.data.operation == OP_READ && rd_onscreen) || div_start;
	assign ram_raddr = (state_q == ST_IDLE) ? rd_idx : idx_q;

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	trz_ram #(.WIDTH(DEPTH_BITS), .DEPTH(PIX_TOTAL)) u_depth_ram (
		.clk(clk), .we(dep_we), .waddr(ram_waddr), .wdata(dep_wdata),
		.re(ram_re), .raddr(ram_raddr), .rdata(dep_rdata)
	);

	trz_ram #(.WIDTH(32), .DEPTH(PIX_TOTAL)) u_colour_ram (
		.clk(clk), .we(dep_we), .waddr(ram_waddr), .wdata(col_wdata),
		.re(ram_re), .raddr(ram_raddr), .rdata(col_rdata)
	);

	trz_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .done(div_done), .quot(div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			pend_q      <= 1'b0;
			clr_addr_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd.data.operation)
							OP_CLEAR: begin
								state_q    <= ST_CLR;
								pend_q     <= 1'b1;
								clr_addr_q <= '0;
							end
							OP_DRAW: state_q <= ST_SET1;
							OP_READ: state_q <= rd_onscreen ? ST_RDW : ST_FIN;
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_SET1: state_q <= ST_SET2;
				ST_SET2: state_q <= ST_SET3;
				ST_SET3: state_q <= ST_SET4;
				ST_SET4: state_q <= (area_q == '0 || empty_q) ? ST_FIN : ST_SET5;
				ST_SET5: state_q <= ST_PIX;
				ST_PIX: begin
					if (covered) begin
						state_q <= ST_DIVW;
					end else if (x_q == xhi_q && y_q == yhi_q) begin
						state_q <= ST_FIN;
					end
				end
				ST_DIVW: begin
					if (div_done) begin
						state_q <= (x_q == xhi_q && y_q == yhi_q) ? ST_FIN : ST_PIX;
					end
				end
				ST_RDW: state_q <= ST_FIN;
				ST_CLR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == ADDR_W'(PIX_TOTAL - 1)) begin
						state_q <= pend_q ? ST_FIN : ST_IDLE;
						pend_q  <= 1'b0;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			rsp_q <= res_q;
		end
		case (state_q)
			ST_IDLE: begin
				cmd_q <= cmd.data;
				res_q <= '0;
				cnt_q <= '0;
			end
			ST_SET1: begin
				dx_q[0] <= diff(cmd_q.by_row, cmd_q.cy);
				dy_q[0] <= diff(cmd_q.cx, cmd_q.bx);
				ox_q[0] <= diff(xlo16, cmd_q.bx);
				oy_q[0] <= diff(ylo16, cmd_q.by_row);
				dx_q[1] <= diff(cmd_q.cy, cmd_q.ay);
				dy_q[1] <= diff(cmd_q.ax, cmd_q.cx);
				ox_q[1] <= diff(xlo16, cmd_q.cx);
				oy_q[1] <= diff(ylo16, cmd_q.cy);
				dx_q[2] <= diff(cmd_q.ay, cmd_q.by_row);
				dy_q[2] <= diff(cmd_q.bx, cmd_q.ax);
				ox_q[2] <= diff(xlo16, cmd_q.ax);
				oy_q[2] <= diff(ylo16, cmd_q.ay);
				acx_q   <= diff(cmd_q.cx, cmd_q.ax);
				acy_q   <= diff(cmd_q.cy, cmd_q.ay);
				xlo_q   <= xlo16[XW-1:0];
				xhi_q   <= xhi16[XW-1:0];
				ylo_q   <= ylo16[YW-1:0];
				yhi_q   <= yhi16[YW-1:0];
				empty_q <= (xlo16 > xhi16) || (ylo16 > yhi16);
			end
			ST_SET2: begin
				for (int i = 0; i < 3; i++) begin
					pex_q[i] <= mul_dd(dx_q[i], ox_q[i]);
					pey_q[i] <= mul_dd(dy_q[i], oy_q[i]);
					pnx_q[i] <= mul_dz(dx_q[i], zv[i]);
					pny_q[i] <= mul_dz(dy_q[i], zv[i]);
				end
				parx_q <= mul_dd(dx_q[2], acx_q);
				pary_q <= mul_dd(dy_q[2], acy_q);
			end
			ST_SET3: begin
				for (int i = 0; i < 3; i++) begin
					e_q[i] <= EW'(pex_q[i]) + EW'(pey_q[i]);
				end
				area_q <= EW'(parx_q) + EW'(pary_q);
				nx_q   <= NW'(pnx_q[0]) + NW'(pnx_q[1]) + NW'(pnx_q[2]);
				ny_q   <= NW'(pny_q[0]) + NW'(pny_q[1]) + NW'(pny_q[2]);
			end
			ST_SET4: begin
				for (int i = 0; i < 3; i++) begin
					ph_q[i] <= PHW'($signed(e_q[i][EW-1:SPLIT])) * $signed(PHW'(zv[i]));
					pl_q[i] <= $signed(PLW'(e_q[i][SPLIT-1:0])) * $signed(PLW'(zv[i]));
				end
				res_q.degenerate <= (area_q == '0);
			end
			ST_SET5: begin
				num_q    <= n0;
				numrow_q <= n0;
				for (int i = 0; i < 3; i++) begin
					er_q[i] <= e_q[i];
				end
				x_q      <= xlo_q;
				y_q      <= ylo_q;
				idx_q    <= ADDR_W'(ylo_q) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(xlo_q);
				rowidx_q <= ADDR_W'(ylo_q) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(xlo_q);
			end
			ST_RDW: begin
				res_q.pixel_colour <= col_rdata;
				res_q.pixel_depth  <= 24'(dep_rdata);
			end
			default: ;
		endcase
		if (adv) begin
			cnt_q <= cnt_nxt;
			if (x_q == xhi_q) begin
				if (y_q == yhi_q) begin
					res_q.pixels_written <= cnt_nxt;
				end else begin
					y_q <= y_q + 1'b1;
					x_q <= xlo_q;
					for (int i = 0; i < 3; i++) begin
						e_q[i]  <= er_q[i] + EW'(dy_q[i]);
						er_q[i] <= er_q[i] + EW'(dy_q[i]);
					end
					num_q    <= numrow_q + ny_q;
					numrow_q <= numrow_q + ny_q;
					idx_q    <= rowidx_q + ADDR_W'(SCREEN_WIDTH);
					rowidx_q <= rowidx_q + ADDR_W'(SCREEN_WIDTH);
				end
			end else begin
				x_q <= x_q + 1'b1;
				for (int i = 0; i < 3; i++) begin
					e_q[i] <= e_q[i] + EW'(dx_q[i]);
				end
				num_q <= num_q + nx_q;
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		dep_we |-> (state_q == ST_CLR || state_q == ST_DIVW))
		else $error("store written outside clearing or depth test");

	assert property (@(posedge clk) disable iff (!arst_n)
		(dep_we && state_q == ST_DIVW) |-> (dep_wdata < dep_rdata))
		else $error("depth written that is not nearer than the stored one");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_FIN))
		else $error("response raised without a finished command");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> (state_q == ST_DIVW))
		else $error("divider started without waiting for its quotient");
endmodule
